// ----- hdl/ksp_pkg.sv -----
// ----------------------------------------------------------------------------
// ksp_pkg
// Shared types and constants of the keyframe spline sampler.
// ----------------------------------------------------------------------------
package ksp_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int NLANE        = 4;
  localparam int QDEPTH       = 2;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam int DIV_NW = 49;
  localparam int DIV_DW = 33;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_KEY_COUNT    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_START_TIME   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_RANGE_LENGTH = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_BOUNDS_MODE  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_INTERP_MODE  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_TANGENT      = 3'd5;

  localparam logic [1:0] BND_NONE  = 2'd0;
  localparam logic [1:0] BND_CLAMP = 2'd1;
  localparam logic [1:0] BND_LOOP  = 2'd2;

  localparam logic INTERP_LINEAR  = 1'b0;
  localparam logic INTERP_HERMITE = 1'b1;

  localparam logic [31:0] TANGENT_RESET = 32'd32768;

  typedef enum logic [1:0] {
    KIND_INTERP = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [6:0]  key_count;
    logic [31:0] start_time;
    logic [30:0] range_length;
    logic [1:0]  bounds_mode;
    logic        interp_mode;
    logic [31:0] tangent_scale;
  } cfg_t;

  typedef struct packed {
    logic [31:0]                t;
    logic [NLANE-1:0][31:0]     v;
  } key_t;

  typedef struct packed {
    logic        eval;
    logic [5:0]  slot;
    key_t        key;
    logic [31:0] query;
  } cmd_t;

endpackage

// ----- hdl/ksp_front.sv -----
// ----------------------------------------------------------------------------
// ksp_front
// Input side: takes transactions, drops writes beyond the table and pushes
// the rest as commands into the queue.
// ----------------------------------------------------------------------------
module ksp_front #(
  parameter int MAX_KEYS = ksp_pkg::MAX_KEYS_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [5:0]        in_key_slot,
  input  logic [31:0]       in_key_time,
  input  logic [31:0]       in_key_x,
  input  logic [31:0]       in_key_y,
  input  logic [31:0]       in_key_w,
  input  logic [31:0]       in_key_h,
  input  logic [31:0]       in_query_time,
  input  logic              q_full,
  output logic              q_push,
  output ksp_pkg::cmd_t     q_cmd
);
  import ksp_pkg::*;

  logic slot_ok;

  assign slot_ok  = 32'(in_key_slot) < 32'(MAX_KEYS);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && ((in_op == OP_EVAL) || slot_ok);

  always_comb begin
    q_cmd.eval     = (in_op == OP_EVAL);
    q_cmd.slot     = in_key_slot;
    q_cmd.key.t    = in_key_time;
    q_cmd.key.v[0] = in_key_x;
    q_cmd.key.v[1] = in_key_y;
    q_cmd.key.v[2] = in_key_w;
    q_cmd.key.v[3] = in_key_h;
    q_cmd.query    = in_query_time;
  end

endmodule

// ----- hdl/ksp_fifo.sv -----
// ----------------------------------------------------------------------------
// ksp_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module ksp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ksp_pkg::cmd_t  wdata,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output ksp_pkg::cmd_t  rdata
);
  import ksp_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign avail   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/ksp_div.sv -----
// ----------------------------------------------------------------------------
// ksp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ksp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ksp_pkg::DIV_NW-1:0] dividend,
  input  logic [ksp_pkg::DIV_DW-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [ksp_pkg::DIV_NW-1:0] quot,
  output logic [ksp_pkg::DIV_DW-1:0] rem
);
  import ksp_pkg::*;

  localparam int CNTW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] r_r, d_r;
  logic [CNTW-1:0]   cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   sh, diff;
  logic              ge;

  assign sh   = {r_r, q_r[DIV_NW-1]};
  assign diff = sh - {1'b0, d_r};
  assign ge   = !diff[DIV_DW];

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DIV_NW);
        q_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[DIV_NW-2:0], ge};
        r_r   <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/ksp_back.sv -----
// ----------------------------------------------------------------------------
// ksp_back
// Execution side: key table, range handling, key search, segment fraction,
// per-lane interpolation and the result register.
// ----------------------------------------------------------------------------
module ksp_back #(
  parameter int MAX_KEYS = ksp_pkg::MAX_KEYS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ksp_pkg::cfg_t  cfg,
  input  logic           q_avail,
  input  ksp_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_x,
  output logic [31:0]    out_y,
  output logic [31:0]    out_w,
  output logic [31:0]    out_h,
  output logic [1:0]     out_result_kind
);
  import ksp_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  localparam logic [3:0] STEP_TAN0  = 4'd0;
  localparam logic [3:0] STEP_TAN1  = 4'd1;
  localparam logic [3:0] STEP_MAC0  = 4'd2;
  localparam logic [3:0] STEP_MAC1  = 4'd3;
  localparam logic [3:0] STEP_MAC2  = 4'd4;
  localparam logic [3:0] STEP_MAC3  = 4'd5;
  localparam logic [3:0] STEP_MAC4  = 4'd6;
  localparam logic [3:0] STEP_MAC5  = 4'd7;
  localparam logic [3:0] STEP_DRAIN = 4'd8;
  localparam logic [3:0] STEP_STORE = 4'd9;

  typedef enum logic [4:0] {
    S_IDLE, S_RANGE, S_LOOP, S_SRCH, S_SCMP, S_DRD, S_DGET,
    S_PRD, S_PGET, S_MRD, S_MGET, S_NRD, S_NGET,
    S_FRAC, S_FDIV, S_B0, S_B1, S_B2, S_LANE, S_DONE
  } state_t;

  state_t state_r;

  key_t          mem [MAX_KEYS];
  key_t          rd_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic [CW-1:0] n_cfg, n_r, lo_r, slen_r, half, mid, p_idx, k_idx, nx_idx;
  logic signed [33:0] q_r;
  logic signed [31:0] t0_r, t1_r;
  logic [NLANE-1:0][31:0] vpm_r, v0_r, v1_r, vin_r, res_r;
  kind_t kind_r;
  logic [15:0] s_r;
  logic [31:0] s2_r;
  logic [47:0] s3_r;
  logic signed [17:0] h00_r, h01_r, h10_r, h11_r;
  logic signed [64:0] tprod_r;
  logic signed [48:0] m0_r, m1_r;
  logic signed [51:0] prod_r;
  logic prod_sh_r, prod_v_r;
  logic signed [67:0] acc_r;
  logic [3:0] op_r;
  logic [1:0] lane_r;

  logic out_valid_r;
  logic [NLANE-1:0][31:0] out_r;
  kind_t out_kind_r;

  logic div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_n, div_quot;
  logic [DIV_DW-1:0] div_d, div_rem;

  logic signed [33:0] st, en, diff, qd_abs;
  logic signed [32:0] span;
  logic signed [34:0] off;
  logic [DIV_DW-1:0] lp_m;
  logic signed [50:0] s3e, s2h, h00n, h01n, h10n, h11n;
  logic signed [31:0] lv0, lv1, lvpm, lvin;
  logic signed [32:0] d0, d1, t_d;
  logic signed [64:0] tmul;
  logic signed [17:0] mac_a;
  logic signed [33:0] mac_b;
  logic mac_sh, mac_go;
  logic signed [67:0] acc_q, prod_x;
  logic [31:0] sat_v;
  logic out_free;

  ksp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign n_cfg = (32'(cfg.key_count) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(cfg.key_count);
  assign q_pop = (state_r == S_IDLE) && q_avail;
  assign mem_we = q_pop && !q_cmd.eval;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    half   = slen_r >> 1;
    mid    = lo_r + half;
    p_idx  = lo_r - CW'(1);
    k_idx  = (lo_r >= n_r) ? n_r - CW'(1) : lo_r;
    nx_idx = (lo_r + CW'(1) < n_r) ? lo_r + CW'(1) : '0;
    unique case (state_r)
      S_SRCH:  rd_addr = AW'(mid);
      S_DRD:   rd_addr = AW'(k_idx);
      S_PRD:   rd_addr = AW'(p_idx);
      S_MRD:   rd_addr = (p_idx == '0) ? AW'(n_r - CW'(1)) : AW'(p_idx - CW'(1));
      S_NRD:   rd_addr = AW'(nx_idx);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    st     = 34'($signed(cfg.start_time));
    en     = st + $signed({3'b000, cfg.range_length});
    diff   = q_r - st;
    qd_abs = diff[33] ? -diff : diff;
    lp_m   = (diff[33] && div_rem != '0) ? DIV_DW'(cfg.range_length) - div_rem : div_rem;
    span   = 33'(t1_r) - 33'(t0_r);
    off    = 35'(q_r) - 35'(t0_r);

    div_start = 1'b0;
    div_n     = DIV_NW'(qd_abs);
    div_d     = DIV_DW'(cfg.range_length);
    if (state_r == S_RANGE) begin
      div_start = (q_r < st || q_r >= en) && (cfg.bounds_mode == BND_LOOP) &&
                  (cfg.range_length != '0);
    end else if (state_r == S_FRAC) begin
      div_start = !(span <= 0 || off < 0) && !(off >= 35'(span));
      div_n     = {off[32:0], 16'h0000};
      div_d     = span[32:0];
    end

    s3e  = 51'(s3_r);
    s2h  = 51'(s2_r) <<< 16;
    h00n = 2 * s3e - 3 * s2h + (51'sd1 <<< 48);
    h01n = 3 * s2h - 2 * s3e;
    h10n = s3e - 2 * s2h + (51'(s_r) <<< 32);
    h11n = s3e - s2h;

    lv0  = $signed(v0_r[lane_r]);
    lv1  = $signed(v1_r[lane_r]);
    lvpm = $signed(vpm_r[lane_r]);
    lvin = $signed(vin_r[lane_r]);
    d0   = 33'(lv1) - 33'(lvpm);
    d1   = 33'(lvin) - 33'(lv0);
    t_d  = (op_r == STEP_TAN0) ? d0 : d1;
    tmul = $signed(cfg.tangent_scale) * t_d;

    mac_go = 1'b0;
    mac_sh = 1'b0;
    mac_a  = '0;
    mac_b  = '0;
    if (state_r == S_LANE) begin
      if (cfg.interp_mode == INTERP_LINEAR) begin
        if (op_r == STEP_MAC0) begin
          mac_go = 1'b1;
          mac_a  = 18'sd65536;
          mac_b  = 34'(lv0);
        end else if (op_r == STEP_MAC1) begin
          mac_go = 1'b1;
          mac_a  = $signed({2'b00, s_r});
          mac_b  = 34'(lv1) - 34'(lv0);
        end
      end else begin
        mac_go = (op_r >= STEP_MAC0) && (op_r <= STEP_MAC5);
        unique case (op_r)
          STEP_MAC0: begin mac_a = h00_r; mac_b = 34'(lv0); end
          STEP_MAC1: begin mac_a = h01_r; mac_b = 34'(lv1); end
          STEP_MAC2: begin mac_a = h10_r; mac_b = $signed({10'b0, m0_r[23:0]}); end
          STEP_MAC3: begin mac_a = h10_r; mac_b = 34'($signed(m0_r[48:24])); mac_sh = 1'b1; end
          STEP_MAC4: begin mac_a = h11_r; mac_b = $signed({10'b0, m1_r[23:0]}); end
          STEP_MAC5: begin mac_a = h11_r; mac_b = 34'($signed(m1_r[48:24])); mac_sh = 1'b1; end
          default:   begin mac_a = '0; mac_b = '0; end
        endcase
      end
    end

    prod_x = prod_sh_r ? (68'(prod_r) <<< 24) : 68'(prod_r);
    acc_q  = acc_r >>> 16;
    if (acc_q > 68'sd2147483647) begin
      sat_v = 32'h7FFF_FFFF;
    end else if (acc_q < -68'sd2147483648) begin
      sat_v = 32'h8000_0000;
    end else begin
      sat_v = acc_q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(q_cmd.slot)] <= q_cmd.key;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
    end else begin
      prod_v_r  <= mac_go;
      prod_r    <= mac_a * mac_b;
      prod_sh_r <= mac_sh;
      if (prod_v_r) begin
        acc_r <= acc_r + prod_x;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_avail && q_cmd.eval) begin
            q_r    <= 34'($signed(q_cmd.query));
            n_r    <= n_cfg;
            res_r  <= '0;
            kind_r <= KIND_NONE;
            state_r <= (n_cfg == '0) ? S_DONE : S_RANGE;
          end
        end
        S_RANGE: begin
          lo_r   <= '0;
          slen_r <= n_r;
          if (q_r < st || q_r >= en) begin
            unique case (cfg.bounds_mode)
              BND_CLAMP: begin
                q_r     <= (q_r < st) ? st : en;
                state_r <= S_SRCH;
              end
              BND_LOOP: begin
                if (cfg.range_length == '0) begin
                  q_r     <= st;
                  state_r <= S_SRCH;
                end else begin
                  state_r <= S_LOOP;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end else begin
            state_r <= S_SRCH;
          end
        end
        S_LOOP: begin
          if (div_done) begin
            q_r     <= st + $signed({1'b0, lp_m});
            state_r <= S_SRCH;
          end
        end
        S_SRCH: state_r <= (slen_r == '0) ? S_DRD : S_SCMP;
        S_SCMP: begin
          if (34'($signed(rd_r.t)) < q_r) begin
            lo_r   <= mid + CW'(1);
            slen_r <= slen_r - half - CW'(1);
          end else begin
            slen_r <= half;
          end
          state_r <= S_SRCH;
        end
        S_DRD: state_r <= S_DGET;
        S_DGET: begin
          if (lo_r >= n_r || lo_r == '0 || 34'($signed(rd_r.t)) == q_r) begin
            res_r   <= rd_r.v;
            kind_r  <= KIND_KEY;
            state_r <= S_DONE;
          end else begin
            v1_r    <= rd_r.v;
            t1_r    <= $signed(rd_r.t);
            state_r <= S_PRD;
          end
        end
        S_PRD: state_r <= S_PGET;
        S_PGET: begin
          v0_r    <= rd_r.v;
          t0_r    <= $signed(rd_r.t);
          state_r <= S_MRD;
        end
        S_MRD: state_r <= S_MGET;
        S_MGET: begin
          vpm_r   <= rd_r.v;
          state_r <= S_NRD;
        end
        S_NRD: state_r <= S_NGET;
        S_NGET: begin
          vin_r   <= rd_r.v;
          state_r <= S_FRAC;
        end
        S_FRAC: begin
          if (span <= 0 || off < 0) begin
            s_r     <= '0;
            state_r <= S_B0;
          end else if (off >= 35'(span)) begin
            s_r     <= 16'hFFFF;
            state_r <= S_B0;
          end else begin
            state_r <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            s_r     <= div_quot[15:0];
            state_r <= S_B0;
          end
        end
        S_B0: begin
          s2_r    <= s_r * s_r;
          state_r <= S_B1;
        end
        S_B1: begin
          s3_r    <= s2_r * s_r;
          state_r <= S_B2;
        end
        S_B2: begin
          h00_r   <= 18'(h00n >>> 32);
          h01_r   <= 18'(h01n >>> 32);
          h10_r   <= 18'(h10n >>> 32);
          h11_r   <= 18'(h11n >>> 32);
          lane_r  <= '0;
          op_r    <= STEP_TAN0;
          acc_r   <= '0;
          state_r <= S_LANE;
        end
        S_LANE: begin
          if (op_r == STEP_TAN0) begin
            tprod_r <= tmul;
          end else if (op_r == STEP_TAN1) begin
            m0_r    <= 49'(tprod_r >>> 16);
            tprod_r <= tmul;
          end else if (op_r == STEP_MAC0) begin
            m1_r <= 49'(tprod_r >>> 16);
          end
          if (op_r == STEP_STORE) begin
            res_r[lane_r] <= sat_v;
            acc_r         <= '0;
            op_r          <= STEP_TAN0;
            lane_r        <= lane_r + 1'b1;
            if (lane_r == 2'(NLANE - 1)) begin
              kind_r  <= KIND_INTERP;
              state_r <= S_DONE;
            end
          end else begin
            op_r <= op_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_r       <= res_r;
            out_kind_r  <= kind_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_r[0];
  assign out_y           = out_r[1];
  assign out_w           = out_r[2];
  assign out_h           = out_r[3];
  assign out_result_kind = out_kind_r;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_LOOP || state_r == S_FDIV))
    else $error("divider result with no waiting state");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP) |-> ({1'b0, lo_r} + {1'b0, slen_r} <= {1'b0, n_r}))
    else $error("search window beyond key count");

endmodule

// ----- hdl/keyframe_spline_sampler.sv -----
// ----------------------------------------------------------------------------
// keyframe_spline_sampler
// Keyframe table with clamp/loop time handling and linear or cardinal
// Hermite sampling of four Q16.16 lanes.
// ----------------------------------------------------------------------------
// A key write is stored into the table as the back end takes it from the
// queue. An evaluate runs as one sequence on a single-ported key table: a
// range step, a loop modulo when the query wraps, a lower-bound search by
// halving steps, the reads of the key and its neighbors, a fraction divide
// in the shared bit-serial divider, the basis steps and a pass per lane in
// the shared multiply-accumulate. Items with no neighbors to blend finish
// early: an empty table or an out-of-range query with no bounds handling
// skips the search, and an exact key hit or an end of the table finishes
// after the search. A two-entry queue separates the input from the
// back end, and the result register lets the next item start while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module keyframe_spline_sampler #(
  parameter int MAX_KEYS = ksp_pkg::MAX_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ksp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ksp_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [5:0]                  in_key_slot,
  input  logic [31:0]                 in_key_time,
  input  logic [31:0]                 in_key_x,
  input  logic [31:0]                 in_key_y,
  input  logic [31:0]                 in_key_w,
  input  logic [31:0]                 in_key_h,
  input  logic [31:0]                 in_query_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_x,
  output logic [31:0]                 out_y,
  output logic [31:0]                 out_w,
  output logic [31:0]                 out_h,
  output logic [1:0]                  out_result_kind
);
  import ksp_pkg::*;

  cfg_t cfg_r;
  cmd_t push_cmd, head_cmd;
  logic q_push, q_full, q_pop, q_avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_count     <= '0;
      cfg_r.start_time    <= '0;
      cfg_r.range_length  <= '0;
      cfg_r.bounds_mode   <= BND_NONE;
      cfg_r.interp_mode   <= INTERP_LINEAR;
      cfg_r.tangent_scale <= TANGENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_COUNT:    cfg_r.key_count     <= cfg_data[6:0];
        CFG_START_TIME:   cfg_r.start_time    <= cfg_data;
        CFG_RANGE_LENGTH: cfg_r.range_length  <= cfg_data[30:0];
        CFG_BOUNDS_MODE:  cfg_r.bounds_mode   <= cfg_data[1:0];
        CFG_INTERP_MODE:  cfg_r.interp_mode   <= cfg_data[0];
        CFG_TANGENT:      cfg_r.tangent_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  ksp_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_key_slot   (in_key_slot),
    .in_key_time   (in_key_time),
    .in_key_x      (in_key_x),
    .in_key_y      (in_key_y),
    .in_key_w      (in_key_w),
    .in_key_h      (in_key_h),
    .in_query_time (in_query_time),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  ksp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .avail (q_avail),
    .rdata (head_cmd)
  );

  ksp_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_avail         (q_avail),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_w           (out_w),
    .out_h           (out_h),
    .out_result_kind (out_result_kind)
  );

endmodule
